### rtl/fsc_pkg.sv
`timescale 1ns / 1ps

package fsc_pkg;

	localparam int DIV_W = 24;
	localparam int CNT_W = 5;

	localparam logic [DIV_W-1:0] RPM_NUM   = 24'd1000000;
	localparam logic [DIV_W-1:0] PCT_SCALE = 24'd100;
	localparam logic [6:0]       FULL_PCT  = 7'd100;

	typedef enum logic [2:0] {
		REG_PWM_RANGE  = 3'd0,
		REG_KICK_SPEED = 3'd1,
		REG_MIN_SPEED  = 3'd2,
		REG_MAX_SPEED  = 3'd3,
		REG_STOP_TEMP  = 3'd4,
		REG_FULL_TEMP  = 3'd5,
		REG_START_TEMP = 3'd6,
		REG_PPR        = 3'd7
	} reg_idx_t;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PREP = 6'b000010,
		S_DIV  = 6'b000100,
		S_DEC  = 6'b001000,
		S_LOAD = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	typedef enum logic [2:0] {
		OP_RPM1 = 3'd0,
		OP_RPM2 = 3'd1,
		OP_TGT  = 3'd2,
		OP_KICK = 3'd3,
		OP_DUTY = 3'd4
	} div_op_t;

	typedef struct packed {
		logic [15:0] duty;
		logic [6:0]  speed;
		logic        written;
		logic        last;
	} res_t;

endpackage

### rtl/fan_speed_controller_top.sv
`timescale 1ns / 1ps

// Fan speed controller: temperature curve and tachometer speed measurement.
// Input channel (s_axis): one transaction is either a temperature sample
// (tuser 0, tdata[7:0] signed degrees C) or a tach edge (tuser 1,
// tdata[31:8] interval in microseconds).
// Output channel (m_axis): one transaction per input, two when a stopped fan
// needs a kick-start; tlast marks the final one, tuser marks a PWM update.
// Configuration: cfg_we writes cfg_data into register cfg_addr;
// write only while the block is idle.
// Arithmetic: all arithmetic runs through one shared restoring divider, one
// quotient bit per cycle. A tach edge takes two divisions (none with a zero
// interval), a sample that changes the speed one or two divisions, and a
// kick-start one more; a sample with no change needs at most one division.
// One item is processed at a time.
// The output register lets the next input be accepted while the final
// result still waits; a stalled receiver holds any result that is ready to
// leave, and processing halts until the output register frees.
// Reset clears the output valid flag, the speed, duty and rpm state and loads
// the default register values; no clearing pass is needed.

module fan_speed_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // temperature[7:0], edge_interval_us[31:8]
	input  logic        s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // duty[15:0], speed_percent[22:16],
	                                   // fan_rpm[48:23], zero[55:49]
	output logic        m_axis_tuser,  // duty_written
	output logic        m_axis_tlast
);

	logic [15:0]       range_q;
	logic [6:0]        kick_speed_q;
	logic [6:0]        min_q;
	logic [6:0]        max_q;
	logic signed [7:0] stop_q;
	logic signed [7:0] full_q;
	logic signed [7:0] start_q;
	logic [3:0]        ppr_q;

	logic [6:0]  present_speed_q;
	logic [15:0] present_duty_q;
	logic [25:0] measured_rpm_q;
	logic        edge_seen_q;

	fsc_pkg::state_t state_q, state_d;

	logic              func_q;
	logic signed [7:0] temp_q;
	logic [23:0]       dt_q;

	logic signed [17:0] tgt_q;
	logic               neg_q;
	logic [6:0]         c_q;
	logic               kick_pend_q;
	fsc_pkg::res_t      res_q;

	logic [fsc_pkg::DIV_W-1:0] div_q_q;
	logic [fsc_pkg::DIV_W-1:0] div_r_q;
	logic [fsc_pkg::DIV_W-1:0] div_d_q;
	logic [fsc_pkg::CNT_W-1:0] div_cnt_q;
	fsc_pkg::div_op_t          op_q;

	logic                      start_en;
	logic [fsc_pkg::DIV_W-1:0] start_dvd;
	logic [fsc_pkg::DIV_W-1:0] start_dvs;
	fsc_pkg::div_op_t          start_op;

	logic [fsc_pkg::DIV_W:0] rem_sh;
	logic [fsc_pkg::DIV_W:0] rem_sub;
	logic                    rem_ge;

	logic signed [8:0]  den_w, diff_w, dspd_w;
	logic signed [17:0] mn_x, den_x, diff_x, dspd_x, num_w;
	logic [17:0]        num_mag;
	logic [8:0]         den_mag;
	logic               t_below, t_have;

	logic [6:0]  kick_eff;
	logic [6:0]  clamp_w;
	logic        tgt_ne;
	logic [6:0]  load_pct;
	logic [22:0] duty_prod;
	logic [3:0]  ppr_eff;
	logic [25:0] rpm_w;
	logic [17:0] tgt_div;

	logic        out_valid_q;
	logic [15:0] out_duty_q;
	logic [6:0]  out_speed_q;
	logic [25:0] out_rpm_q;
	logic        out_wr_q;
	logic        out_last_q;
	logic        out_free;

	assign s_axis_tready = (state_q == fsc_pkg::S_IDLE);
	assign out_free      = !out_valid_q || m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_rpm_q, out_speed_q, out_duty_q};
	assign m_axis_tuser  = out_wr_q;
	assign m_axis_tlast  = out_last_q;

	// curve arithmetic
	assign den_w   = {full_q[7], full_q} - {stop_q[7], stop_q};
	assign diff_w  = {temp_q[7], temp_q} - {stop_q[7], stop_q};
	assign dspd_w  = {2'b00, max_q} - {2'b00, min_q};
	assign mn_x    = {11'd0, min_q};
	assign den_x   = {{9{den_w[8]}}, den_w};
	assign diff_x  = {{9{diff_w[8]}}, diff_w};
	assign dspd_x  = {{9{dspd_w[8]}}, dspd_w};
	assign num_w   = mn_x * den_x + diff_x * dspd_x;
	assign num_mag = num_w[17] ? (~num_w + 18'd1) : num_w;
	assign den_mag = den_w[8] ? (~den_w + 9'd1) : den_w;
	assign t_below = temp_q < stop_q;
	assign t_have  = (present_speed_q != 7'd0) || (temp_q >= start_q);

	assign kick_eff = (kick_speed_q > fsc_pkg::FULL_PCT) ? fsc_pkg::FULL_PCT : kick_speed_q;
	assign tgt_ne   = tgt_q != {11'd0, present_speed_q};

	always_comb begin
		if (tgt_q[17]) begin
			clamp_w = 7'd0;
		end else if (tgt_q > 18'sd100) begin
			clamp_w = fsc_pkg::FULL_PCT;
		end else begin
			clamp_w = tgt_q[6:0];
		end
	end

	assign load_pct  = kick_pend_q ? kick_eff : c_q;
	assign duty_prod = {7'd0, range_q} * {16'd0, load_pct};
	assign ppr_eff   = (ppr_q == 4'd0) ? 4'd1 : ppr_q;
	// rpm = quotient * 60
	assign rpm_w     = {div_q_q[19:0], 6'd0} - {4'd0, div_q_q[19:0], 2'd0};
	assign tgt_div   = neg_q ? (~div_q_q[17:0] + 18'd1) : div_q_q[17:0];

	// restoring divider step
	assign rem_sh  = {div_r_q, div_q_q[fsc_pkg::DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, div_d_q};
	assign rem_ge  = rem_sh >= {1'b0, div_d_q};

	always_comb begin
		state_d   = state_q;
		start_en  = 1'b0;
		start_dvd = '0;
		start_dvs = '0;
		start_op  = fsc_pkg::OP_TGT;
		case (state_q)
			fsc_pkg::S_IDLE: begin
				if (s_axis_tvalid) state_d = fsc_pkg::S_PREP;
			end
			fsc_pkg::S_PREP: begin
				if (func_q) begin
					if (dt_q == 24'd0) begin
						state_d = fsc_pkg::S_EMIT;
					end else begin
						start_en  = 1'b1;
						start_dvd = fsc_pkg::RPM_NUM;
						start_dvs = dt_q;
						start_op  = fsc_pkg::OP_RPM1;
					end
				end else if (t_below) begin
					state_d = fsc_pkg::S_DEC;
				end else if (t_have) begin
					if (den_w == 9'sd0) begin
						state_d = fsc_pkg::S_DEC;
					end else begin
						start_en  = 1'b1;
						start_dvd = {6'd0, num_mag};
						start_dvs = {15'd0, den_mag};
						start_op  = fsc_pkg::OP_TGT;
					end
				end else begin
					state_d = fsc_pkg::S_EMIT;
				end
			end
			fsc_pkg::S_DIV: begin
				if (div_cnt_q == '0) begin
					case (op_q)
						fsc_pkg::OP_RPM1: begin
							start_en  = 1'b1;
							start_dvd = {4'd0, div_q_q[19:0]};
							start_dvs = {20'd0, ppr_eff};
							start_op  = fsc_pkg::OP_RPM2;
						end
						fsc_pkg::OP_TGT: state_d = fsc_pkg::S_DEC;
						default: state_d = fsc_pkg::S_EMIT;
					endcase
				end
			end
			fsc_pkg::S_DEC: begin
				state_d = tgt_ne ? fsc_pkg::S_LOAD : fsc_pkg::S_EMIT;
			end
			fsc_pkg::S_LOAD: begin
				start_en  = 1'b1;
				start_dvd = {1'b0, duty_prod};
				start_dvs = fsc_pkg::PCT_SCALE;
				start_op  = kick_pend_q ? fsc_pkg::OP_KICK : fsc_pkg::OP_DUTY;
			end
			fsc_pkg::S_EMIT: begin
				if (out_free) state_d = res_q.last ? fsc_pkg::S_IDLE : fsc_pkg::S_LOAD;
			end
			default: state_d = fsc_pkg::S_IDLE;
		endcase
		if (start_en) state_d = fsc_pkg::S_DIV;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fsc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q      <= 16'd1080;
			kick_speed_q <= 7'd35;
			min_q        <= 7'd10;
			max_q        <= 7'd80;
			stop_q       <= 8'sd35;
			full_q       <= 8'sd75;
			start_q      <= 8'sd42;
			ppr_q        <= 4'd2;
		end else if (cfg_we) begin
			case (cfg_addr)
				fsc_pkg::REG_PWM_RANGE:  range_q      <= cfg_data;
				fsc_pkg::REG_KICK_SPEED: kick_speed_q <= cfg_data[6:0];
				fsc_pkg::REG_MIN_SPEED:  min_q        <= cfg_data[6:0];
				fsc_pkg::REG_MAX_SPEED:  max_q        <= cfg_data[6:0];
				fsc_pkg::REG_STOP_TEMP:  stop_q       <= cfg_data[7:0];
				fsc_pkg::REG_FULL_TEMP:  full_q       <= cfg_data[7:0];
				fsc_pkg::REG_START_TEMP: start_q      <= cfg_data[7:0];
				fsc_pkg::REG_PPR:        ppr_q        <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// fan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_speed_q <= 7'd0;
			present_duty_q  <= 16'd0;
			measured_rpm_q  <= 26'd0;
			edge_seen_q     <= 1'b0;
		end else begin
			if (state_q == fsc_pkg::S_PREP) begin
				if (func_q) begin
					edge_seen_q <= 1'b1;
				end else begin
					if (!edge_seen_q) measured_rpm_q <= 26'd0;
					edge_seen_q <= 1'b0;
				end
			end
			if (state_q == fsc_pkg::S_DIV && div_cnt_q == '0) begin
				if (op_q == fsc_pkg::OP_RPM2) measured_rpm_q <= rpm_w;
				if (op_q == fsc_pkg::OP_DUTY) begin
					present_speed_q <= c_q;
					present_duty_q  <= div_q_q[15:0];
				end
			end
		end
	end

	// item payload and working registers
	always_ff @(posedge clk) begin
		if (state_q == fsc_pkg::S_IDLE && s_axis_tvalid) begin
			func_q <= s_axis_tuser;
			temp_q <= s_axis_tdata[7:0];
			dt_q   <= s_axis_tdata[31:8];
		end
		case (state_q)
			fsc_pkg::S_PREP: begin
				tgt_q <= t_below ? 18'sd0 : {11'd0, max_q};
				neg_q <= num_w[17] ^ den_w[8];
				res_q <= '{duty: present_duty_q, speed: present_speed_q,
				           written: 1'b0, last: 1'b1};
			end
			fsc_pkg::S_DIV: begin
				if (div_cnt_q == '0) begin
					case (op_q)
						fsc_pkg::OP_TGT: tgt_q <= tgt_div;
						fsc_pkg::OP_KICK: res_q <= '{duty: div_q_q[15:0], speed: kick_eff,
						                            written: 1'b1, last: 1'b0};
						fsc_pkg::OP_DUTY: res_q <= '{duty: div_q_q[15:0], speed: c_q,
						                            written: 1'b1, last: 1'b1};
						default: ;
					endcase
				end
			end
			fsc_pkg::S_DEC: begin
				c_q         <= clamp_w;
				kick_pend_q <= (present_speed_q == 7'd0) && (clamp_w != 7'd0)
				               && (clamp_w < kick_eff);
			end
			fsc_pkg::S_EMIT: begin
				if (out_free) kick_pend_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// shared divider, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			op_q      <= fsc_pkg::OP_TGT;
		end else if (start_en) begin
			div_cnt_q <= fsc_pkg::CNT_W'(fsc_pkg::DIV_W);
			op_q      <= start_op;
		end else if (state_q == fsc_pkg::S_DIV && div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start_en) begin
			div_q_q <= start_dvd;
			div_r_q <= '0;
			div_d_q <= start_dvs;
		end else if (state_q == fsc_pkg::S_DIV && div_cnt_q != '0) begin
			div_q_q <= {div_q_q[fsc_pkg::DIV_W-2:0], rem_ge};
			div_r_q <= rem_ge ? rem_sub[fsc_pkg::DIV_W-1:0] : rem_sh[fsc_pkg::DIV_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == fsc_pkg::S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fsc_pkg::S_EMIT && out_free) begin
			out_duty_q  <= res_q.duty;
			out_speed_q <= res_q.speed;
			out_rpm_q   <= measured_rpm_q;
			out_wr_q    <= res_q.written;
			out_last_q  <= res_q.last;
		end
	end

endmodule
